FILE: hdl/jvss_pkg.sv
// Shared types and constants for the JSON value span scanner.
package jvss_pkg;

   // Fixed byte codes of the JSON syntax.
   localparam logic [7:0] QUOTE_CHAR  = 8'h22;
   localparam logic [7:0] ESCAPE_CHAR = 8'h5C;

   // Width of the offsets carried in a result.
   localparam int OUT_BITS = 32;

   // Reset values of the configurable bracket bytes.
   localparam logic [7:0] OPEN_RESET  = 8'd123;
   localparam logic [7:0] CLOSE_RESET = 8'd125;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_KEY_LOW   = 3'd0,
      CSR_KEY_HIGH  = 3'd1,
      CSR_KEY_LEN   = 3'd2,
      CSR_OPEN_CHAR = 3'd3,
      CSR_CLOSE_CHAR = 3'd4
   } csr_index_type;

   // Scan phases of one text.
   typedef enum logic [1:0] {
      PH_MATCH = 2'd0,
      PH_SEEK  = 2'd1,
      PH_TRACK = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   // One result item.
   typedef struct packed {
      logic                found;
      logic [OUT_BITS-1:0] span_begin;
      logic [OUT_BITS-1:0] span_end;
      logic                position_overflow;
   } rsp_item_type;

endpackage

FILE: hdl/jvss_window_cell.sv
// One cell of the key window: holds one recent byte and checks its needle byte.
module jvss_window_cell #(
   parameter int MAX_KEY_BYTES = 16,
   parameter int IDX           = 0,
   parameter int LEN_BITS      = 5,
   parameter int KEY_IDX_BITS  = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic                           clear,
   input  logic [7:0]                     shift_data,
   input  logic [MAX_KEY_BYTES-1:0][7:0]  key_chars,
   input  logic [LEN_BITS-1:0]            key_len,
   output logic [7:0]                     byte_out,
   output logic                           hit
);
   import jvss_pkg::*;

   localparam logic [LEN_BITS:0] IDX_L = (LEN_BITS+1)'(IDX);

   logic [7:0]        byte_ff;
   logic [7:0]        byte_in;
   logic [LEN_BITS:0] len_ext;
   logic [LEN_BITS:0] sel_full;

   assign byte_out = byte_ff;
   assign len_ext  = {1'b0, key_len};
   assign sel_full = len_ext - IDX_L;

   // The byte moving into this cell is compared, so the check sees the window
   // as it stands after the current byte has shifted in.
   always_comb begin
      if (IDX == 0) begin
         hit = (shift_data == QUOTE_CHAR);
      end else if (IDX_L == len_ext + 1'b1) begin
         hit = (shift_data == QUOTE_CHAR);
      end else if (IDX_L <= len_ext) begin
         hit = (shift_data == key_chars[sel_full[KEY_IDX_BITS-1:0]]);
      end else begin
         hit = 1'b1;
      end
   end

   // Shift register stage.
   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = 8'd0;
      end else if (shift_en) begin
         byte_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

endmodule

FILE: hdl/jvss_span_tracker.sv
// Phase control, nesting depth, string skipping and byte position counting.
module jvss_span_tracker #(
   parameter int POSITION_BITS = 32,
   parameter int DEPTH_BITS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             ch,
   input  logic                   last,
   input  logic                   window_hit,
   input  logic [7:0]             open_char,
   input  logic [7:0]             close_char,
   output logic                   emit,
   output jvss_pkg::rsp_item_type result
);
   import jvss_pkg::*;

   phase_type                phase_ff, phase_in, phase_mid;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_next;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [DEPTH_BITS-1:0]    depth_ff, depth_in;
   logic                     str_ff, str_in;
   logic                     skip_ff, skip_in;
   logic                     ovf_ff, ovf_in;
   logic                     pos_max;
   logic                     span_close;

   assign pos_max  = (pos_ff == '1);
   assign pos_next = pos_max ? pos_ff : pos_ff + 1'b1;

   // Next phase: key match leads to the open search, the open byte starts tracking.
   always_comb begin
      phase_mid = phase_ff;
      case (phase_ff)
         PH_MATCH: if (window_hit) phase_mid = PH_SEEK;
         PH_SEEK:  if (ch == open_char) phase_mid = PH_TRACK;
         default:  phase_mid = phase_ff;
      endcase
      phase_in = span_close ? PH_DONE : phase_mid;
   end

   // Depth tracking and result forming for the current byte.
   always_comb begin
      depth_in   = depth_ff;
      str_in     = str_ff;
      skip_in    = skip_ff;
      start_in   = start_ff;
      span_close = 1'b0;
      ovf_in     = ovf_ff | pos_max;
      pos_in     = pos_next;
      if (phase_ff == PH_SEEK && phase_mid == PH_TRACK) begin
         start_in = pos_ff;
      end
      if (phase_mid == PH_TRACK) begin
         if (skip_ff) begin
            skip_in = 1'b0;
         end else if (str_ff) begin
            if (ch == ESCAPE_CHAR) begin
               skip_in = 1'b1;
            end else if (ch == QUOTE_CHAR) begin
               str_in = 1'b0;
            end
         end else if (ch == QUOTE_CHAR) begin
            str_in = 1'b1;
         end else if (ch == open_char) begin
            depth_in = depth_ff + 1'b1;
         end else if (ch == close_char) begin
            depth_in = depth_ff - 1'b1;
            span_close = (depth_in == '0);
         end
      end
      emit = span_close | (last & (phase_mid != PH_DONE));
      result.found             = span_close;
      result.span_begin        = span_close ? OUT_BITS'(start_in) : '0;
      result.span_end          = span_close ? OUT_BITS'(pos_next) : '0;
      result.position_overflow = ovf_in;
   end

   // State registers; the last byte of a text clears everything.
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff <= PH_MATCH;
         pos_ff   <= '0;
         start_ff <= '0;
         depth_ff <= '0;
         str_ff   <= 1'b0;
         skip_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         depth_ff <= depth_in;
         str_ff   <= str_in;
         skip_ff  <= skip_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Nonzero depth only exists while a value is being tracked.
   assert property (@(posedge clock) disable iff (reset)
      (depth_ff != '0) |-> (phase_ff == PH_TRACK))
      else $error("nesting depth nonzero outside tracking");

   // String state only exists while a value is being tracked.
   assert property (@(posedge clock) disable iff (reset)
      (str_ff || skip_ff) |-> (phase_ff == PH_TRACK))
      else $error("string state set outside tracking");

   // The last byte of a text returns the scanner to its start.
   assert property (@(posedge clock) disable iff (reset)
      (step && last) |=> (pos_ff == '0 && phase_ff == PH_MATCH))
      else $error("scanner not cleared after text end");

endmodule

FILE: hdl/json_value_span_scanner_core.sv
// Top level of the JSON value span scanner: window cells, tracker and result register.
//
//   Channel  Direction  Transfer when           Content
//   req_     in         req_tvalid & ready      tdata: data_byte; tlast: text_end
//   rsp_     out        rsp_tvalid & ready      tdata: span_begin, span_end, overflow;
//                                               tuser: found
//   csr_     in         csr_valid & csr_ready   csr_index, csr_data
//
// One byte is taken every cycle unless input stalls; the window compare and depth
// update settle in the same cycle; the result shows in the output register next cycle.
// A waiting result does not stop input while the consumer takes it in that cycle;
// input stalls only while the output register holds an untaken result.
// Synchronous reset clears the window, the scan state and the output register and
// loads the register reset values; no clearing pass is needed.
module json_value_span_scanner_core #(
   parameter int MAX_KEY_BYTES = 16,
   parameter int POSITION_BITS = 32,
   parameter int DEPTH_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // text_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] span_begin, [63:32] span_end,
                                    // [64] position_overflow, [71:65] zero
   output logic        rsp_tuser,   // found
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import jvss_pkg::*;

   localparam int WIN_LEN      = MAX_KEY_BYTES + 2;
   localparam int LEN_BITS     = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_IDX_BITS = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   logic [63:0]                    key_low_ff, key_high_ff;
   logic [4:0]                     key_len_ff;
   logic [7:0]                     open_ff, close_ff;
   logic [127:0]                   key_flat;
   logic [MAX_KEY_BYTES-1:0][7:0]  key_chars;
   logic [LEN_BITS-1:0]            key_len;
   logic [WIN_LEN-1:0][7:0]        win_bytes;
   logic [WIN_LEN-1:0]             win_hits;
   logic                           step;
   logic                           emit;
   rsp_item_type                   result;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_item_type                   rsp_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
         open_ff     <= OPEN_RESET;
         close_ff    <= CLOSE_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_LOW:    key_low_ff  <= csr_data;
            CSR_KEY_HIGH:   key_high_ff <= csr_data;
            CSR_KEY_LEN:    key_len_ff  <= csr_data[4:0];
            CSR_OPEN_CHAR:  open_ff     <= csr_data[7:0];
            CSR_CLOSE_CHAR: close_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Key bytes in use, and the key length held to MAX_KEY_BYTES.
   assign key_flat  = {key_high_ff, key_low_ff};
   assign key_chars = key_flat[MAX_KEY_BYTES*8-1:0];
   assign key_len   = (key_len_ff > 5'(MAX_KEY_BYTES)) ? LEN_BITS'(MAX_KEY_BYTES)
                                                       : LEN_BITS'(key_len_ff);

   assign step = req_tvalid & req_tready;

   // Window cells: cell 0 takes the new byte, each later cell takes its neighbor's.
   for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
      jvss_window_cell #(
         .MAX_KEY_BYTES (MAX_KEY_BYTES),
         .IDX           (i),
         .LEN_BITS      (LEN_BITS),
         .KEY_IDX_BITS  (KEY_IDX_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (step),
         .clear      (step & req_tlast),
         .shift_data ((i == 0) ? req_tdata : win_bytes[(i == 0) ? 0 : i-1]),
         .key_chars  (key_chars),
         .key_len    (key_len),
         .byte_out   (win_bytes[i]),
         .hit        (win_hits[i])
      );
   end

   jvss_span_tracker #(
      .POSITION_BITS (POSITION_BITS),
      .DEPTH_BITS    (DEPTH_BITS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .ch         (req_tdata),
      .last       (req_tlast),
      .window_hit (&win_hits),
      .open_char  (open_ff),
      .close_char (close_ff),
      .emit       (emit),
      .result     (result)
   );

   // Output register; a new byte is taken when it is empty or being emptied.
   assign req_tready = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.found;
   assign rsp_tdata  = {7'd0, rsp_ff.position_overflow, rsp_ff.span_end, rsp_ff.span_begin};

   // A result only appears after a byte transfer.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_tvalid && req_tready))
      else $error("result without a byte transfer");

   // A not-found result carries an empty span.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |->
         (rsp_ff.span_begin == '0 && rsp_ff.span_end == '0))
      else $error("not-found result with nonzero span");

   // A not-found result is caused only by the last byte of a text.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !rsp_ff.found) |-> $past(req_tlast))
      else $error("not-found result before text end");

endmodule

FILE: dv/span_scan_checker.sv
// Checker for the JSON value span scanner: tracks the text stream, predicts spans and compares.
`timescale 1ns / 100ps

module span_scan_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          mismatches,
   output int          outstanding
);
   import jvss_pkg::*;

   localparam int          KEY_SLOTS = 16;
   localparam int          WIN_LEN   = KEY_SLOTS + 2;
   localparam logic [31:0] POS_LIMIT = '1;

   // Register copies.
   logic [63:0] key_low;
   logic [63:0] key_high;
   logic [4:0]  key_len;
   logic [7:0]  open_byte;
   logic [7:0]  close_byte;

   // Scan state of the current text.
   phase_type   phase;
   logic [7:0]  window [WIN_LEN];
   logic [31:0] byte_pos;
   logic [31:0] value_start;
   logic [15:0] depth;
   logic        in_string;
   logic        skip_byte;
   logic        saturated;

   rsp_item_type pending_spans[$];
   int           error_count;

   function automatic logic [7:0] key_char(int i);
      return (i < 8) ? key_low[8*i +: 8] : key_high[8*(i-8) +: 8];
   endfunction

   // The newest byte sits in slot zero, so the key appears reversed in the window.
   function automatic bit needle_in_window();
      int len;
      len = (key_len > KEY_SLOTS) ? KEY_SLOTS : int'(key_len);
      if (window[0] != QUOTE_CHAR || window[len + 1] != QUOTE_CHAR) return 1'b0;
      for (int k = 0; k < len; k++) begin
         if (window[1 + k] != key_char(len - 1 - k)) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic clear_scan();
      phase = PH_MATCH;
      foreach (window[i]) window[i] = '0;
      byte_pos    = '0;
      value_start = '0;
      depth       = '0;
      in_string   = 1'b0;
      skip_byte   = 1'b0;
      saturated   = 1'b0;
   endtask

   // Advance the scan by one byte and queue the span it completes, if any.
   task automatic scan_byte(input logic [7:0] ch, input logic last);
      logic [31:0]  at;
      bit           reported;
      rsp_item_type span;
      at = byte_pos;
      reported = 1'b0;
      if (at == POS_LIMIT) saturated = 1'b1;
      for (int i = WIN_LEN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = ch;

      if (phase == PH_MATCH) begin
         if (needle_in_window()) phase = PH_SEEK;
      end else if (phase == PH_SEEK && ch == open_byte) begin
         value_start = at;
         phase = PH_TRACK;
      end

      // Depth tracking; quotes take priority over the bracket bytes.
      if (phase == PH_TRACK) begin
         if (skip_byte) begin
            skip_byte = 1'b0;
         end else if (in_string) begin
            if (ch == ESCAPE_CHAR) skip_byte = 1'b1;
            else if (ch == QUOTE_CHAR) in_string = 1'b0;
         end else if (ch == QUOTE_CHAR) begin
            in_string = 1'b1;
         end else if (ch == open_byte) begin
            depth = depth + 1'b1;
         end else if (ch == close_byte) begin
            depth = depth - 1'b1;
            if (depth == '0) begin
               span.found             = 1'b1;
               span.span_begin        = value_start;
               span.span_end          = (at == POS_LIMIT) ? at : at + 1'b1;
               span.position_overflow = saturated;
               pending_spans.push_back(span);
               reported = 1'b1;
               phase = PH_DONE;
            end
         end
      end

      if (at != POS_LIMIT) byte_pos = at + 1'b1;

      // End of text: report a miss unless a span already came, then start over.
      if (last) begin
         if (!reported && phase != PH_DONE) begin
            span.found             = 1'b0;
            span.span_begin        = '0;
            span.span_end          = '0;
            span.position_overflow = saturated;
            pending_spans.push_back(span);
         end
         clear_scan();
      end
   endtask

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: span mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         key_low    = '0;
         key_high   = '0;
         key_len    = '0;
         open_byte  = OPEN_RESET;
         close_byte = CLOSE_RESET;
         clear_scan();
         pending_spans.delete();
         error_count = 0;
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_LOW:    key_low    = csr_data;
               CSR_KEY_HIGH:   key_high   = csr_data;
               CSR_KEY_LEN:    key_len    = csr_data[4:0];
               CSR_OPEN_CHAR:  open_byte  = csr_data[7:0];
               CSR_CLOSE_CHAR: close_byte = csr_data[7:0];
               default: ;
            endcase
         end

         // Result transfers against the oldest expected span.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_spans.size() == 0) begin
               note_error($sformatf("unexpected result found=%0b begin=%0d end=%0d overflow=%0b",
                                    rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[64]));
            end else begin
               want = pending_spans.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata[31:0] !== want.span_begin ||
                   rsp_tdata[63:32] !== want.span_end ||
                   rsp_tdata[64] !== want.position_overflow || rsp_tdata[71:65] !== '0) begin
                  note_error($sformatf({"expected found=%0b begin=%0d end=%0d overflow=%0b, ",
                                        "got found=%0b begin=%0d end=%0d overflow=%0b pad=%0h"},
                                       want.found, want.span_begin, want.span_end,
                                       want.position_overflow, rsp_tuser, rsp_tdata[31:0],
                                       rsp_tdata[63:32], rsp_tdata[64], rsp_tdata[71:65]));
               end
            end
         end

         // Byte transfers.
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
      end
      mismatches  <= error_count;
      outstanding <= pending_spans.size();
   end

endmodule

FILE: dv/json_value_span_scanner_core_test.sv
// Testbench top for the JSON value span scanner: clock, reset, text stimulus and verdict.
`timescale 1ns / 100ps

module json_value_span_scanner_core_test;
   import jvss_pkg::*;

   localparam int         ITEM_TARGET     = 1420;
   localparam int         PHASE_ITEMS     = 120;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam logic [2:0] CSR_SPARE_FIRST = 3'd5;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [63:0] csr_data   = '0;

   int mismatches;
   int outstanding;
   int items_sent     = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 18;
   int recv_idle_pct  = 71;

   // Register values as last written, used to shape the texts.
   logic [63:0] cfg_key_low  = '0;
   logic [63:0] cfg_key_high = '0;
   logic [4:0]  cfg_key_len  = '0;
   logic [7:0]  cfg_open     = OPEN_RESET;
   logic [7:0]  cfg_close    = CLOSE_RESET;

   logic [7:0] text_bytes[$];

   json_value_span_scanner_core dut (.*);

   span_scan_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side readiness.
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int needle_len();
      return (cfg_key_len > 16) ? 16 : int'(cfg_key_len);
   endfunction

   function automatic logic [7:0] key_char_of(int i);
      return (i < 8) ? cfg_key_low[8*i +: 8] : cfg_key_high[8*(i-8) +: 8];
   endfunction

   // Bytes biased toward the ones the scanner reacts to.
   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(7))
         0: return QUOTE_CHAR;
         1: return ESCAPE_CHAR;
         2: return cfg_open;
         3: return cfg_close;
         4: return (needle_len() > 0) ? key_char_of($urandom_range(needle_len() - 1))
                                      : 8'($urandom_range(255));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Quote, key, quote; a spoiled copy has one bit flipped somewhere.
   task automatic push_needle(input bit spoil);
      int base;
      base = text_bytes.size();
      text_bytes.push_back(QUOTE_CHAR);
      for (int i = 0; i < needle_len(); i++) text_bytes.push_back(key_char_of(i));
      text_bytes.push_back(QUOTE_CHAR);
      if (spoil) text_bytes[base + $urandom_range(needle_len() + 1)] ^= 8'(1 << $urandom_range(7));
   endtask

   // A bracketed value with nested levels, strings and escapes inside.
   task automatic push_value(input bit complete);
      int level;
      int n;
      level = 1;
      text_bytes.push_back(cfg_open);
      repeat ($urandom_range(12)) begin
         case ($urandom_range(9))
            0, 1: begin
               text_bytes.push_back(cfg_open);
               level++;
            end
            2, 3: if (level > 1) begin
               text_bytes.push_back(cfg_close);
               level--;
            end
            4, 5: begin
               n = $urandom_range(5);
               text_bytes.push_back(QUOTE_CHAR);
               repeat (n) begin
                  if ($urandom_range(3) == 0) text_bytes.push_back(ESCAPE_CHAR);
                  text_bytes.push_back(pick_text_byte());
               end
               text_bytes.push_back(QUOTE_CHAR);
            end
            default: text_bytes.push_back(8'($urandom_range(255)));
         endcase
      end
      if (complete) repeat (level) text_bytes.push_back(cfg_close);
   endtask

   // One byte transfer, after a random idle stretch.
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   // Stop input and wait until every expected result has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all registers, plus one unused index, with valid held across transfers.
   task automatic write_config(input logic [63:0] low, input logic [63:0] high,
                               input logic [4:0] len, input logic [7:0] open_b,
                               input logic [7:0] close_b);
      logic [2:0]  slot [6];
      logic [63:0] word [6];
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      slot = '{3'(CSR_SPARE_FIRST + $urandom_range(2)), CSR_KEY_LOW, CSR_KEY_HIGH,
               CSR_KEY_LEN, CSR_OPEN_CHAR, CSR_CLOSE_CHAR};
      word = '{noise, low, high, {noise[63:5], len}, {noise[63:8], open_b},
               {noise[63:8], close_b}};
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= slot[i];
         csr_data  <= word[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cfg_key_low  = low;
      cfg_key_high = high;
      cfg_key_len  = len;
      cfg_open     = open_b;
      cfg_close    = close_b;
   endtask

   initial begin
      int phase_no;
      int phase_end;
      int kind;
      logic [7:0] pick_a;
      logic [7:0] pick_b;
      phase_no = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts with the reset key: escaped close inside a string and nesting,
      // bytes after a span, a text ending mid-value, a one-byte text, and an
      // overlapping quote run in front of the value.
      text_bytes = '{QUOTE_CHAR, QUOTE_CHAR, OPEN_RESET, QUOTE_CHAR, ESCAPE_CHAR, CLOSE_RESET,
                     QUOTE_CHAR, OPEN_RESET, CLOSE_RESET, CLOSE_RESET, 8'hFF};
      send_text();
      text_bytes = '{QUOTE_CHAR, QUOTE_CHAR, CLOSE_RESET, OPEN_RESET, 8'h00};
      send_text();
      text_bytes = '{ESCAPE_CHAR};
      send_text();
      text_bytes = '{QUOTE_CHAR, QUOTE_CHAR, QUOTE_CHAR, OPEN_RESET, CLOSE_RESET};
      send_text();

      // Random texts under a series of register settings.
      while (items_sent < ITEM_TARGET) begin
         drain();
         pick_a = 8'($urandom_range(255));
         pick_b = 8'($urandom_range(255));
         case (phase_no)
            0: write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 8'h5B, 8'h5D);
            1: write_config('0, '0, 5'd0, 8'h00, 8'hFF);
            2: write_config('1, '1, 5'd31, 8'hFF, 8'h00);
            3: write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(4, 1)),
                            QUOTE_CHAR, CLOSE_RESET);
            4: write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(3)),
                            pick_a, pick_a);
            5: write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, OPEN_RESET,
                            QUOTE_CHAR);
            6: write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(8)),
                            8'h28, ESCAPE_CHAR);
            default: write_config({$urandom, $urandom}, {$urandom, $urandom},
                                  5'($urandom_range(31)), pick_a, pick_b);
         endcase
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            if (items_sent < ITEM_TARGET / 3) begin
               send_idle_pct = 18;
               recv_idle_pct = 71;
            end else if (items_sent < 2 * ITEM_TARGET / 3) begin
               send_idle_pct = 71;
               recv_idle_pct = 18;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end

            // Mostly key-then-value texts; some noise, spoiled keys and cut-off values.
            text_bytes.delete();
            kind = $urandom_range(99);
            if (kind < 6) begin
               text_bytes.push_back(pick_text_byte());
            end else if (kind < 18) begin
               repeat ($urandom_range(30, 1)) text_bytes.push_back(pick_text_byte());
            end else begin
               repeat ($urandom_range(3)) text_bytes.push_back(pick_text_byte());
               if (kind < 35) push_needle(1'b1);
               push_needle(kind >= 92);
               repeat ($urandom_range(2)) text_bytes.push_back(pick_text_byte());
               push_value(kind < 84);
               repeat ($urandom_range(3)) text_bytes.push_back(pick_text_byte());
            end
            send_text();
         end
         phase_no++;
      end

      drain();
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
